FILE: rtl/core/mma_pkg.sv
// Shared types, codes and constants of the matrix multiply-accumulate core.
`default_nettype none

package mma_pkg;

    // Default sizes of the stores and of the stored words.
    localparam int DEF_MAX_DIM   = 8;
    localparam int DEF_WORD_BITS = 32;

    // Fixed field widths.
    localparam int FRAC_BITS      = 16;
    localparam int IDX_BITS       = 3;
    localparam int DIM_BITS       = 4;
    localparam int VALUE_BITS     = 32;
    localparam int CMD_BITS       = 2;
    localparam int CFG_INDEX_BITS = 2;

    // Size register reset value.
    localparam logic [DIM_BITS-1:0] DIM_RESET = 4'd8;

    // Command codes.
    localparam logic [CMD_BITS-1:0] CMD_LOAD_A   = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_LOAD_B   = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_LOAD_ACC = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_COMPUTE  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROWS_USED  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INNER_USED = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLS_USED  = 2'd2;

    // Input beat.
    typedef struct packed {
        logic [CMD_BITS-1:0]          command;
        logic [IDX_BITS-1:0]          row;
        logic [IDX_BITS-1:0]          col;
        logic signed [VALUE_BITS-1:0] value;
    } t_in_beat;

    // Result beat.
    typedef struct packed {
        logic signed [VALUE_BITS-1:0] result;
        logic [IDX_BITS-1:0]          out_row;
        logic [IDX_BITS-1:0]          out_col;
        logic                         last;
    } t_out_beat;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC_RD,
        ST_MAC_MUL,
        ST_MAC_ACC,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/core/matrix_multiply_accumulate_core.sv
// Matrix multiply-accumulate core: out += A x B in signed Q16.16 over on-chip stores.
//
//  Channel   Signals                                Direction  Handshake
//  command   start, busy, i_cmd (t_in_beat)         in         start && !busy
//  result    o_strobe, o_res (t_out_beat)           out        one-cycle strobe
//  config    i_cfg_we, i_cfg_index, i_cfg_data      in         write enable
//
// A load beat leaves busy low, so loads can follow back to back.
// A compute beat holds busy high while each multiply-accumulate step reads the A, B
// and output memories, multiplies, then adds, saturates and writes back through the
// output-memory write port; then one result a cycle is read out.
// The last result strobes in the same cycle that busy falls.
// Reset clears the output store at once through per-entry valid bits; no clearing pass.
// Results cannot be stalled; each is on the ports for exactly one cycle.
`default_nettype none

module matrix_multiply_accumulate_core #(
    parameter int MAX_DIM   = mma_pkg::DEF_MAX_DIM,
    parameter int WORD_BITS = mma_pkg::DEF_WORD_BITS
) (
    input  wire                                        i_clk,
    input  wire                                        i_rst_n,
    input  wire                                        start,
    output logic                                       busy,
    input  wire mma_pkg::t_in_beat                     i_cmd,
    output logic                                       o_strobe,
    output mma_pkg::t_out_beat                         o_res,
    input  wire                                        i_cfg_we,
    input  wire [mma_pkg::CFG_INDEX_BITS-1:0]          i_cfg_index,
    input  wire [mma_pkg::DIM_BITS-1:0]                i_cfg_data
);

    localparam int DEPTH    = MAX_DIM * MAX_DIM;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W    = mma_pkg::IDX_BITS;
    localparam int DIM_W    = mma_pkg::DIM_BITS;
    localparam int RES_BITS = mma_pkg::VALUE_BITS;
    localparam int FRAC     = mma_pkg::FRAC_BITS;
    localparam int PROD_W   = 2 * WORD_BITS;
    localparam int SUM_W    = PROD_W - FRAC + 1;

    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(MAX_DIM);
    localparam logic [DIM_W-1:0] DIM_ONE   = DIM_W'(1);

    // Flat store address of an element.
    function automatic logic [ADDR_W-1:0] f_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
        return ADDR_W'(int'(r) * MAX_DIM + int'(c));
    endfunction

    // Effective size of a size register.
    function automatic logic [DIM_W-1:0] f_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] d;
        d = v;
        if (v == '0) begin
            d = DIM_ONE;
        end else if (v > DIM_LIMIT) begin
            d = DIM_LIMIT;
        end
        return d;
    endfunction

    // Configuration registers.
    logic [DIM_W-1:0] r_rows_used, r_inner_used, r_cols_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_used  <= mma_pkg::DIM_RESET;
            r_inner_used <= mma_pkg::DIM_RESET;
            r_cols_used  <= mma_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mma_pkg::REG_ROWS_USED:  r_rows_used  <= i_cfg_data;
                mma_pkg::REG_INNER_USED: r_inner_used <= i_cfg_data;
                mma_pkg::REG_COLS_USED:  r_cols_used  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [DIM_W-1:0] dim_m, dim_k, dim_n;
    assign dim_m = f_dim(r_rows_used);
    assign dim_k = f_dim(r_inner_used);
    assign dim_n = f_dim(r_cols_used);

    // Sequencer state and loop counters.
    mma_pkg::t_state   r_state, n_state;
    logic [IDX_W-1:0]  r_i, n_i, r_p, n_p, r_j, n_j;
    logic              r_pend, n_pend;
    logic [IDX_W-1:0]  r_out_row, n_out_row, r_out_col, n_out_col;
    logic              r_out_last, n_out_last;

    // Memories and their registered read data.
    logic [WORD_BITS-1:0] r_mem_a   [DEPTH];
    logic [WORD_BITS-1:0] r_mem_b   [DEPTH];
    logic [WORD_BITS-1:0] r_mem_acc [DEPTH];
    logic [DEPTH-1:0]     r_acc_vld;
    logic signed [WORD_BITS-1:0] r_a_rdata, r_b_rdata, r_acc_rdata;
    logic                 r_acc_rvld;
    logic signed [PROD_W-1:0] r_prod;

    // Accepted load beats and their range checks.
    logic accept, load_a, load_b, load_acc;
    logic in_m_row, in_k_row, in_k_col, in_n_col;

    assign accept   = start && !busy;
    assign in_m_row = DIM_W'(i_cmd.row) < dim_m;
    assign in_k_row = DIM_W'(i_cmd.row) < dim_k;
    assign in_k_col = DIM_W'(i_cmd.col) < dim_k;
    assign in_n_col = DIM_W'(i_cmd.col) < dim_n;
    assign load_a   = accept && i_cmd.command == mma_pkg::CMD_LOAD_A && in_m_row && in_k_col;
    assign load_b   = accept && i_cmd.command == mma_pkg::CMD_LOAD_B && in_k_row && in_n_col;
    assign load_acc = accept && i_cmd.command == mma_pkg::CMD_LOAD_ACC
                      && in_m_row && in_n_col;

    logic [ADDR_W-1:0]    load_addr;
    logic [WORD_BITS-1:0] load_word;
    assign load_addr = f_addr(i_cmd.row, i_cmd.col);
    assign load_word = i_cmd.value[WORD_BITS-1:0];

    // Accumulate: shift the product down, add, saturate.
    logic signed [WORD_BITS-1:0] acc_old, acc_new;
    logic signed [SUM_W-1:0]     sum;
    logic [SUM_W-WORD_BITS:0]    sum_hi;

    assign acc_old = r_acc_rvld ? r_acc_rdata : '0;
    assign sum     = SUM_W'($signed(r_prod[PROD_W-1:FRAC])) + SUM_W'(acc_old);
    assign sum_hi  = sum[SUM_W-1:WORD_BITS-1];

    always_comb begin
        if ((&sum_hi) || !(|sum_hi)) begin
            acc_new = sum[WORD_BITS-1:0];
        end else if (sum[SUM_W-1]) begin
            acc_new = WORD_MIN;
        end else begin
            acc_new = WORD_MAX;
        end
    end

    // Output memory read and write ports.
    logic                 acc_rd_en, acc_we;
    logic [ADDR_W-1:0]    acc_waddr;
    logic [WORD_BITS-1:0] acc_wdata;

    assign acc_rd_en = (r_state == mma_pkg::ST_MAC_RD) || (r_state == mma_pkg::ST_EMIT);
    assign acc_we    = load_acc || (r_state == mma_pkg::ST_MAC_ACC);
    assign acc_waddr = load_acc ? load_addr : f_addr(r_i, r_j);
    assign acc_wdata = load_acc ? load_word : acc_new;

    // A and B stores.
    always_ff @(posedge i_clk) begin
        if (load_a) begin
            r_mem_a[load_addr] <= load_word;
        end
        if (load_b) begin
            r_mem_b[load_addr] <= load_word;
        end
        if (r_state == mma_pkg::ST_MAC_RD) begin
            r_a_rdata <= r_mem_a[f_addr(r_i, r_p)];
            r_b_rdata <= r_mem_b[f_addr(r_p, r_j)];
        end
    end

    // Output store.
    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            r_mem_acc[acc_waddr] <= acc_wdata;
        end
        if (acc_rd_en) begin
            r_acc_rdata <= r_mem_acc[f_addr(r_i, r_j)];
        end
    end

    // Valid bits make a never-written output entry read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld  <= '0;
            r_acc_rvld <= 1'b0;
        end else begin
            if (acc_we) begin
                r_acc_vld[acc_waddr] <= 1'b1;
            end
            if (acc_rd_en) begin
                r_acc_rvld <= r_acc_vld[f_addr(r_i, r_j)];
            end
        end
    end

    // Product register.
    always_ff @(posedge i_clk) begin
        if (r_state == mma_pkg::ST_MAC_MUL) begin
            r_prod <= r_a_rdata * r_b_rdata;
        end
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mma_pkg::ST_IDLE;
            r_i        <= '0;
            r_p        <= '0;
            r_j        <= '0;
            r_pend     <= 1'b0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_last <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_i        <= n_i;
            r_p        <= n_p;
            r_j        <= n_j;
            r_pend     <= n_pend;
            r_out_row  <= n_out_row;
            r_out_col  <= n_out_col;
            r_out_last <= n_out_last;
        end
    end

    logic last_i, last_p, last_j;
    assign last_i = DIM_W'(r_i) == (dim_m - DIM_ONE);
    assign last_p = DIM_W'(r_p) == (dim_k - DIM_ONE);
    assign last_j = DIM_W'(r_j) == (dim_n - DIM_ONE);

    // Next state: walk i, then p, then j for the update, then i, j for readout.
    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_p        = r_p;
        n_j        = r_j;
        n_pend     = 1'b0;
        n_out_row  = r_out_row;
        n_out_col  = r_out_col;
        n_out_last = r_out_last;
        unique case (r_state)
            mma_pkg::ST_IDLE: begin
                if (accept && i_cmd.command == mma_pkg::CMD_COMPUTE) begin
                    n_state = mma_pkg::ST_MAC_RD;
                    n_i     = '0;
                    n_p     = '0;
                    n_j     = '0;
                end
            end
            mma_pkg::ST_MAC_RD: begin
                n_state = mma_pkg::ST_MAC_MUL;
            end
            mma_pkg::ST_MAC_MUL: begin
                n_state = mma_pkg::ST_MAC_ACC;
            end
            mma_pkg::ST_MAC_ACC: begin
                n_state = mma_pkg::ST_MAC_RD;
                if (!last_j) begin
                    n_j = r_j + 1'b1;
                end else begin
                    n_j = '0;
                    if (!last_p) begin
                        n_p = r_p + 1'b1;
                    end else begin
                        n_p = '0;
                        if (!last_i) begin
                            n_i = r_i + 1'b1;
                        end else begin
                            n_i     = '0;
                            n_state = mma_pkg::ST_EMIT;
                        end
                    end
                end
            end
            mma_pkg::ST_EMIT: begin
                n_pend     = 1'b1;
                n_out_row  = r_i;
                n_out_col  = r_j;
                n_out_last = last_i && last_j;
                if (!last_j) begin
                    n_j = r_j + 1'b1;
                end else begin
                    n_j = '0;
                    if (!last_i) begin
                        n_i = r_i + 1'b1;
                    end else begin
                        n_i     = '0;
                        n_state = mma_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = mma_pkg::ST_IDLE;
            end
        endcase
    end

    // Ports.
    logic signed [WORD_BITS-1:0] acc_emit;
    assign acc_emit = r_acc_rvld ? r_acc_rdata : '0;

    assign busy            = (r_state != mma_pkg::ST_IDLE);
    assign o_strobe        = r_pend;
    assign o_res.result    = RES_BITS'(acc_emit);
    assign o_res.out_row   = r_out_row;
    assign o_res.out_col   = r_out_col;
    assign o_res.last      = r_out_last;

    // A result beat only follows a readout cycle.
    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state) == mma_pkg::ST_EMIT)
        else $error("result beat without a readout read");

    // Nothing strobes in the cycle after the last result.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.last) |=> !o_strobe)
        else $error("result beat after the last one");

    // A compute beat raises busy.
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd.command == mma_pkg::CMD_COMPUTE) |=> busy)
        else $error("compute beat did not start the sequencer");

    // The write-back of a step always follows its multiply.
    a_mac_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mma_pkg::ST_MAC_ACC) |-> $past(r_state) == mma_pkg::ST_MAC_MUL)
        else $error("accumulate without a product");

endmodule

`default_nettype wire
